/* rtl/bfc_pkg.sv */
// Types, constants and helper functions for the byte ring FIFO with packet flow control.
// Depends on nothing; the controller, the top level and the bench refer to it by scoped names.
`default_nettype none

package bfc_pkg;

	localparam int DEPTH  = 256;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH);

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(DEPTH - 1);

	localparam logic [7:0] MAX_PACKET_RESET = 8'd64;

	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_POP  = 2'd1;
	localparam logic [1:0] FUNC_ZLP  = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       last_of_burst;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
		logic       rearm;
		logic       overflow;
		logic [7:0] fill_count;
		logic [7:0] free_space;
		logic       end_of_file;
	} out_item_t;

	// Request from the controller to the byte store
	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [PTR_W-1:0] raddr;
	} ram_req_t;

	// Result fields known at acceptance; read data joins from the store's registered read port
	typedef struct packed {
		logic       read_valid;
		logic       rearm;
		logic       overflow;
		logic [7:0] fill_count;
		logic [7:0] free_space;
		logic       end_of_file;
	} step_res_t;

	function automatic logic [7:0] sat8(input logic [CNT_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'd255) ? 8'hFF : w[7:0];
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

`default_nettype wire

/* rtl/byte_ring_fifo_with_packet_flow_control_unit.sv */
// Top level of the byte ring FIFO with packet flow control.
// Depends on bfc_pkg, bfc_ram and bfc_ctrl.
//
// One request is taken per clock cycle, every cycle, as long as the output side keeps up.
// Each request gives one result, passing first through the byte store's registered read
// port, which supplies the popped byte, and then through the output register. The ring
// holds DEPTH-1 bytes, in a synchronous RAM. A push into a full
// ring drops the byte and flags overflow. At the end of each packet, rearm pulses if the
// free space exceeds max_packet; otherwise a release is held until a read burst ends with
// at least max_packet bytes free. The store has no clearing pass after reset. max_packet
// resets to 64 and may be written only while the block is idle.
`default_nettype none

module byte_ring_fifo_with_packet_flow_control_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire bfc_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output bfc_pkg::out_item_t      out_item,
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_wdata
);

	bfc_pkg::ram_req_t  ram_req;
	bfc_pkg::step_res_t res, res_s1;
	logic [7:0]         rdata;
	logic               s1_v_q, out_v_q, accept, move;

	assign move     = s1_v_q & (~out_v_q | ~out_stall);
	assign in_stall = s1_v_q & ~move;
	assign accept   = in_valid & ~in_stall;

	bfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ram_req   (ram_req),
		.res       (res)
	);

	bfc_ram #(
		.DEPTH (bfc_pkg::DEPTH),
		.WIDTH (8)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_v_q <= 1'b1;
			end else if (move) begin
				s1_v_q <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (~out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// merge the read port's byte with the stored result fields
	always_ff @(posedge clk) begin
		if (move) begin
			out_item.read_data   <= res_s1.read_valid ? rdata : 8'd0;
			out_item.read_valid  <= res_s1.read_valid;
			out_item.rearm       <= res_s1.rearm;
			out_item.overflow    <= res_s1.overflow;
			out_item.fill_count  <= res_s1.fill_count;
			out_item.free_space  <= res_s1.free_space;
			out_item.end_of_file <= res_s1.end_of_file;
		end
	end

	assign out_valid = out_v_q;

`ifndef ASSERT_OFF
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_v_q)
		else $error("accepted request did not reach the first stage");
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_v_q && out_v_q)
		else $error("input stalled with room in the pipeline");
	a_empty_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.read_valid |-> out_item.read_data == 8'd0)
		else $error("read data present without a popped byte");
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.overflow |-> out_item.free_space == 8'd0)
		else $error("overflow reported with free space");
`endif

endmodule

`default_nettype wire

/* rtl/bfc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; sized by its parameters.
`default_nettype none

module bfc_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/bfc_ctrl.sv */
// Pointer, fill and flow-control state of the ring; issues byte store requests.
// Depends on bfc_pkg.
`default_nettype none

module bfc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire bfc_pkg::in_item_t   item,
	input  wire logic                cfg_we,
	input  wire logic [7:0]          cfg_wdata,
	output bfc_pkg::ram_req_t        ram_req,
	output bfc_pkg::step_res_t       res
);

	logic [bfc_pkg::PTR_W-1:0] wp_q, rp_q, wp_n, rp_n;
	logic [bfc_pkg::CNT_W-1:0] fill_q, fill_n, free_n;
	logic                      pend_q, pend_n, eof_q, eof_n;
	logic [7:0]                max_q;
	logic                      rearm, ovf, rvalid, we, re;

	always_comb begin
		wp_n   = wp_q;
		rp_n   = rp_q;
		fill_n = fill_q;
		pend_n = pend_q;
		eof_n  = eof_q;
		rearm  = 1'b0;
		ovf    = 1'b0;
		rvalid = 1'b0;
		we     = 1'b0;
		re     = 1'b0;
		free_n = bfc_pkg::FILL_MAX - fill_q;
		case (item.func)
			bfc_pkg::FUNC_PUSH: begin
				if (fill_q == bfc_pkg::FILL_MAX) begin
					ovf = 1'b1;
				end else begin
					we     = 1'b1;
					wp_n   = bfc_pkg::ptr_inc(wp_q);
					fill_n = fill_q + bfc_pkg::CNT_W'(1);
				end
				free_n = bfc_pkg::FILL_MAX - fill_n;
				if (item.last_of_burst) begin
					if (32'(free_n) > 32'(max_q)) begin
						rearm = 1'b1;
					end else begin
						pend_n = 1'b1;
					end
				end
			end
			bfc_pkg::FUNC_POP: begin
				if (fill_q != '0) begin
					re     = 1'b1;
					rvalid = 1'b1;
					rp_n   = bfc_pkg::ptr_inc(rp_q);
					fill_n = fill_q - bfc_pkg::CNT_W'(1);
				end
				free_n = bfc_pkg::FILL_MAX - fill_n;
				// release a held packet once the read burst has made room
				if (item.last_of_burst && pend_q && (32'(free_n) >= 32'(max_q))) begin
					pend_n = 1'b0;
					rearm  = 1'b1;
				end
			end
			bfc_pkg::FUNC_ZLP: begin
				eof_n = 1'b1;
				if (32'(free_n) > 32'(max_q)) begin
					rearm = 1'b1;
				end else begin
					pend_n = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
			pend_q <= 1'b0;
			eof_q  <= 1'b0;
			max_q  <= bfc_pkg::MAX_PACKET_RESET;
		end else begin
			if (accept) begin
				wp_q   <= wp_n;
				rp_q   <= rp_n;
				fill_q <= fill_n;
				pend_q <= pend_n;
				eof_q  <= eof_n;
			end
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
		end
	end

	assign ram_req.we    = accept & we;
	assign ram_req.waddr = wp_q;
	assign ram_req.wdata = item.data_byte;
	assign ram_req.re    = accept & re;
	assign ram_req.raddr = rp_q;

	assign res.read_valid  = rvalid;
	assign res.rearm       = rearm;
	assign res.overflow    = ovf;
	assign res.fill_count  = bfc_pkg::sat8(fill_n);
	assign res.free_space  = bfc_pkg::sat8(free_n);
	assign res.end_of_file = eof_n;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= bfc_pkg::FILL_MAX)
		else $error("fill count beyond ring capacity");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> fill_q != bfc_pkg::FILL_MAX)
		else $error("write into a full ring");
	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.re |=> fill_q == $past(fill_q) - bfc_pkg::CNT_W'(1))
		else $error("read did not lower the fill count");
`endif

endmodule

`default_nettype wire

/* tb/tb_byte_ring_fifo_with_packet_flow_control_unit.sv */
// Self-checking bench for the byte ring FIFO with packet flow control: it drives pushes,
// pops and zero-length packets and checks every result against a ring predictor.
// Depends on bfc_pkg and byte_ring_fifo_with_packet_flow_control_unit.
`default_nettype none

module tb_byte_ring_fifo_with_packet_flow_control_unit;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_PHASES = 5;

	class ring_scoreboard;
		logic [7:0] ring_bytes [256];
		logic [7:0] wr_ptr;
		logic [7:0] rd_ptr;
		bit         release_held;
		bit         eof_flag;
		logic [7:0] threshold;
		bfc_pkg::out_item_t pending_results [$];
		int         mismatches;

		function new();
			wr_ptr = '0;
			rd_ptr = '0;
			release_held = 1'b0;
			eof_flag = 1'b0;
			threshold = bfc_pkg::MAX_PACKET_RESET;
			mismatches = 0;
		endfunction

		function void set_threshold(logic [7:0] v);
			threshold = v;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function logic [7:0] fill_now();
			return wr_ptr - rd_ptr;
		endfunction

		function logic [7:0] room_now();
			return 8'd255 - fill_now();
		endfunction

		// Packet end: rearm at once if there is room for a full packet, else hold the release
		function bit packet_closed();
			if (room_now() > threshold)
				return 1'b1;
			release_held = 1'b1;
			return 1'b0;
		endfunction

		function void note_request(bfc_pkg::in_item_t req);
			bfc_pkg::out_item_t res;
			res = '0;
			case (req.func)
				bfc_pkg::FUNC_PUSH: begin
					if (room_now() == 8'd0) begin
						res.overflow = 1'b1;
					end else begin
						ring_bytes[wr_ptr] = req.data_byte;
						wr_ptr = wr_ptr + 8'd1;
					end
					if (req.last_of_burst)
						res.rearm = packet_closed();
				end
				bfc_pkg::FUNC_POP: begin
					if (fill_now() != 8'd0) begin
						res.read_data = ring_bytes[rd_ptr];
						res.read_valid = 1'b1;
						rd_ptr = rd_ptr + 8'd1;
					end
					if (req.last_of_burst && release_held && room_now() >= threshold) begin
						release_held = 1'b0;
						res.rearm = 1'b1;
					end
				end
				bfc_pkg::FUNC_ZLP: begin
					eof_flag = 1'b1;
					res.rearm = packet_closed();
				end
				default: ;
			endcase
			res.fill_count = fill_now();
			res.free_space = room_now();
			res.end_of_file = eof_flag;
			pending_results.push_back(res);
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(bfc_pkg::out_item_t got);
			bfc_pkg::out_item_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			compare("read_data", want.read_data, got.read_data);
			compare("read_valid", want.read_valid, got.read_valid);
			compare("rearm", want.rearm, got.rearm);
			compare("overflow", want.overflow, got.overflow);
			compare("fill_count", want.fill_count, got.fill_count);
			compare("free_space", want.free_space, got.free_space);
			compare("end_of_file", want.end_of_file, got.end_of_file);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	bfc_pkg::in_item_t  in_item = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	bfc_pkg::out_item_t out_item;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	bit         tx_quiet = 1'b0;
	bit         rx_quiet = 1'b0;
	int         cycle_count = 0;
	ring_scoreboard sb;

	byte_ring_fifo_with_packet_flow_control_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_item);
	end

	// Receiver: unless quiet, stall for a randomly drawn hold, then take one result
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (!rx_quiet) begin
				hold = $urandom_range(0, 6);
				if (hold != 0) begin
					out_stall = 1'b1;
					repeat (hold) @(negedge clk);
					out_stall = 1'b0;
				end
			end
			do @(posedge clk); while (!out_valid);
			if ($urandom_range(0, 31) == 0)
				rx_quiet = !rx_quiet;
		end
	end

	function automatic bfc_pkg::in_item_t make_req(logic [1:0] f, logic [7:0] d, logic l);
		bfc_pkg::in_item_t r;
		r.func = f;
		r.data_byte = d;
		r.last_of_burst = l;
		return r;
	endfunction

	task automatic send_request(bfc_pkg::in_item_t req);
		int gap;
		@(negedge clk);
		if (!tx_quiet) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_item = req;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_request(req);
	endtask

	// Drop valid and hold until every result is back
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_threshold(logic [7:0] v);
		drain();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_threshold(v);
	endtask

	// Mostly whole packets and read bursts; a few stray requests and unterminated bursts
	task automatic run_traffic(int n_items, int push_pct, int max_len);
		int done;
		int len;
		int kind;
		bit broken;
		bfc_pkg::in_item_t r;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(0, 7) == 0)
				tx_quiet = !tx_quiet;
			kind = $urandom_range(0, 99);
			broken = ($urandom_range(0, 9) == 0);
			if (kind < 6) begin
				r = make_req(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
				send_request(r);
				if (r.func != FUNC_UNUSED)
					done++;
			end else if (kind < 9) begin
				send_request(make_req(bfc_pkg::FUNC_ZLP, 8'($urandom),
					1'($urandom_range(0, 1))));
				done++;
			end else if ($urandom_range(0, 99) < push_pct) begin
				len = $urandom_range(1, max_len);
				for (int i = 0; i < len; i++)
					send_request(make_req(bfc_pkg::FUNC_PUSH, 8'($urandom),
						(i == len - 1) && !broken));
				done += len;
			end else begin
				len = $urandom_range(1, 24);
				for (int i = 0; i < len; i++)
					send_request(make_req(bfc_pkg::FUNC_POP, 8'($urandom),
						(i == len - 1) && !broken));
				done += len;
			end
		end
	endtask

	initial begin
		int         phase_items [NUM_PHASES] = '{150, 400, 200, 120, 120};
		int         phase_push  [NUM_PHASES] = '{50, 92, 15, 60, 50};
		int         phase_len   [NUM_PHASES] = '{16, 40, 16, 8, 24};
		logic [7:0] phase_thr   [NUM_PHASES];

		sb = new();
		phase_thr[0] = 8'($urandom_range(2, 254));
		phase_thr[1] = 8'd255;
		phase_thr[2] = 8'd0;
		phase_thr[3] = 8'd1;
		phase_thr[4] = 8'($urandom_range(2, 254));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty pops, unused code, byte extremes, packet ends, zero-length packets
		send_request(make_req(bfc_pkg::FUNC_POP, 8'h00, 1'b1));
		send_request(make_req(bfc_pkg::FUNC_POP, 8'hFF, 1'b0));
		send_request(make_req(FUNC_UNUSED, 8'hFF, 1'b1));
		send_request(make_req(bfc_pkg::FUNC_PUSH, 8'h00, 1'b0));
		send_request(make_req(bfc_pkg::FUNC_PUSH, 8'hFF, 1'b1));
		send_request(make_req(bfc_pkg::FUNC_PUSH, 8'hA5, 1'b0));
		send_request(make_req(bfc_pkg::FUNC_PUSH, 8'h5A, 1'b1));
		send_request(make_req(bfc_pkg::FUNC_POP, 8'h00, 1'b0));
		send_request(make_req(bfc_pkg::FUNC_POP, 8'h00, 1'b1));
		send_request(make_req(bfc_pkg::FUNC_ZLP, 8'h3C, 1'b0));
		send_request(make_req(bfc_pkg::FUNC_ZLP, 8'hC3, 1'b1));
		send_request(make_req(FUNC_UNUSED, 8'h00, 1'b0));
		send_request(make_req(bfc_pkg::FUNC_POP, 8'h00, 1'b0));
		send_request(make_req(bfc_pkg::FUNC_POP, 8'h00, 1'b0));
		send_request(make_req(bfc_pkg::FUNC_POP, 8'h00, 1'b1));
		send_request(make_req(bfc_pkg::FUNC_PUSH, 8'h01, 1'b1));
		send_request(make_req(bfc_pkg::FUNC_POP, 8'hFF, 1'b1));

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_threshold(phase_thr[p]);
			run_traffic(phase_items[p], phase_push[p], phase_len[p]);
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
rtl/bfc_pkg.sv
rtl/bfc_ram.sv
rtl/bfc_ctrl.sv
rtl/byte_ring_fifo_with_packet_flow_control_unit.sv
tb/tb_byte_ring_fifo_with_packet_flow_control_unit.sv
